// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on the rising edge, with an
// active-low reset disable. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/lra_pkg.sv =====
// ----------------------------------------------------------------------------
// Literal rank attention package
// Sizes, operation codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam int unsigned MAX_LITERALS = 64;
  localparam int unsigned LIT_W        = $clog2(MAX_LITERALS);
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned CFG_W        = 7;

  localparam logic [1:0] FUNC_ATTN  = 2'd0;
  localparam logic [1:0] FUNC_TYPE1 = 2'd1;
  localparam logic [1:0] FUNC_TYPE2 = 2'd2;

  localparam logic CFG_LITERAL_COUNT  = 1'b0;
  localparam logic CFG_ATTENTION_SPAN = 1'b1;

  typedef logic [LIT_W-1:0] lit_idx_t;

  typedef struct packed {
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic is_t1;
    logic first;
    logic act;
    logic can_sink;
    logic demote;
    logic lit_set;
  } head_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_ATTN     = 5'b00010,
    ST_ATTN_OUT = 5'b00100,
    ST_FEED     = 5'b01000,
    ST_FLUSH    = 5'b10000
  } state_e;

endpackage

// ===== design/lra_if.sv =====
// ----------------------------------------------------------------------------
// Literal rank attention channels
// Request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lra_in_if;
  import lra_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [DATA_W-1:0] literal_bits;
  logic [DATA_W-1:0] included_bits;
  logic [DATA_W-1:0] demote_bits;
  logic              apply_update;

  modport source (output valid, func, literal_bits, included_bits, demote_bits,
                  apply_update, input ready);
  modport sink   (input valid, func, literal_bits, included_bits, demote_bits,
                  apply_update, output ready);
endinterface

interface lra_out_if;
  import lra_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] masked_bits;

  modport source (output valid, masked_bits, input ready);
  modport sink   (input valid, masked_bits, output ready);
endinterface

// ===== design/lra_cell.sv =====
// ----------------------------------------------------------------------------
// Rank cell
// Holds the literal index of one rank and takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module lra_cell
  import lra_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lit_idx_t   init_i,
  input  cell_ctrl_t ctrl_i,
  input  lit_idx_t   next_i,
  output lit_idx_t   q_o
);

  lit_idx_t val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= init_i;
    end else if (ctrl_i.shift) begin
      val_q <= next_i;
    end
  end

  assign q_o = val_q;

endmodule

// ===== design/lra_head.sv =====
// ----------------------------------------------------------------------------
// Rank chain head
// Swap unit at the head of the rank chain: keeps the rank still open to a
// swap and the sinking literal, and emits one settled rank per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lra_head
  import lra_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  head_ctrl_t ctrl_i,
  input  lit_idx_t   s_i,
  output lit_idx_t   emit_o,
  output lit_idx_t   pend_o
);

  lit_idx_t pend_q, pend_d;
  lit_idx_t sink_el_q, sink_el_d;
  logic     carry_q, carry_d;
  logic     up;
  logic     sink;

  always_comb begin
    up        = ctrl_i.act && !ctrl_i.first &&
                (ctrl_i.is_t1 ? ctrl_i.lit_set : !ctrl_i.lit_set);
    sink      = ctrl_i.is_t1 && ctrl_i.can_sink && ctrl_i.demote;
    emit_o    = pend_q;
    pend_d    = pend_q;
    sink_el_d = sink_el_q;
    carry_d   = carry_q;
    if (carry_q) begin
      emit_o = s_i;
      if (!sink) begin
        carry_d = 1'b0;
        pend_d  = sink_el_q;
      end
    end else if (up) begin
      emit_o = s_i;
    end else if (sink && !ctrl_i.lit_set) begin
      carry_d   = 1'b1;
      sink_el_d = s_i;
    end else begin
      pend_d = s_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
    end else if (ctrl_i.start) begin
      carry_q <= 1'b0;
    end else if (ctrl_i.step) begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      pend_q    <= pend_d;
      sink_el_q <= sink_el_d;
    end
  end

  assign pend_o = pend_q;

  `ASSERT_PROP(a_carry_type1, clk_i, rst_ni, carry_q && ctrl_i.step |-> ctrl_i.is_t1 && ctrl_i.act, "sinking literal outside type I pass or past count")
  `ASSERT_PROP(a_start_clears, clk_i, rst_ni, ctrl_i.start |=> !carry_q, "sinking literal survives pass start")
  `ASSERT_NEVER(a_carry_first, clk_i, rst_ni, carry_q && ctrl_i.step && ctrl_i.first, "sinking literal at top rank")

endmodule

// ===== design/literal_rank_attention_core.sv =====
// Attention: ST_ATTN steps every rank past the head, then ST_ATTN_OUT registers the result.
// Type I / type II feedback: busy while ST_FEED steps every rank, then during the ST_FLUSH chain flush.
// Throughput: ready is high only in ST_IDLE, so a new request waits until the pass is done; the rank chain rotates one
// rank past the head per cycle; a held result delays the next attention load.
// Feedback without apply and the unused code: taken in ST_IDLE, which the core does not leave.
// Reset: asynchronous, ranking returns to the identity, count and span to 64.
// ----------------------------------------------------------------------------
// Literal rank attention core
// Keeps a ranking of literals in a rotating chain of cells, masks literals
// by attention span and updates the ranking from type I / type II feedback.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module literal_rank_attention_core
  import lra_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  lra_in_if.sink           req_i,
  lra_out_if.source        res_o
);

  localparam lit_idx_t K_LAST = lit_idx_t'(MAX_LITERALS - 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, span_q;
  lit_idx_t          k_q, k_d;
  logic [1:0]        func_q;
  logic [DATA_W-1:0] lits_q, incl_q, dem_q, res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_bits_q;
  logic              out_load;

  logic [CNT_W-1:0]  n_use;
  logic [CNT_W-1:0]  k_ext;
  lit_idx_t          s;
  lit_idx_t          tail;
  lit_idx_t          emit;
  lit_idx_t          pend;
  lit_idx_t          cell_q [MAX_LITERALS];
  cell_ctrl_t        cell_ctrl;
  head_ctrl_t        head_ctrl;
  logic              accept;

  assign n_use  = (count_q > CNT_W'(MAX_LITERALS)) ? CNT_W'(MAX_LITERALS) : count_q;
  assign k_ext  = CNT_W'(k_q);
  assign s      = cell_q[0];
  assign accept = req_i.valid && req_i.ready;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.masked_bits = out_bits_q;

  genvar j;
  generate
    for (j = 0; j < MAX_LITERALS; j++) begin : g_cell
      lit_idx_t nxt;
      if (j == MAX_LITERALS - 1) begin : g_tail
        assign nxt = tail;
      end else begin : g_mid
        assign nxt = cell_q[j+1];
      end
      lra_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .init_i (lit_idx_t'(j)),
        .ctrl_i (cell_ctrl),
        .next_i (nxt),
        .q_o    (cell_q[j])
      );
    end
  endgenerate

  always_comb begin
    head_ctrl.start    = accept;
    head_ctrl.step     = (state_q == ST_FEED);
    head_ctrl.is_t1    = (func_q == FUNC_TYPE1);
    head_ctrl.first    = (k_q == '0);
    head_ctrl.act      = (k_ext < n_use);
    head_ctrl.can_sink = ((k_ext + CNT_W'(1)) < n_use);
    head_ctrl.demote   = dem_q[0];
    head_ctrl.lit_set  = lits_q[s];
  end

  lra_head u_head (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (head_ctrl),
    .s_i    (s),
    .emit_o (emit),
    .pend_o (pend)
  );

  always_comb begin
    cell_ctrl.shift = 1'b0;
    tail            = s;
    unique case (state_q)
      ST_ATTN: begin
        cell_ctrl.shift = 1'b1;
        tail            = s;
      end
      ST_FEED: begin
        cell_ctrl.shift = 1'b1;
        tail            = emit;
      end
      ST_FLUSH: begin
        cell_ctrl.shift = 1'b1;
        tail            = pend;
      end
      default: begin
        cell_ctrl.shift = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    res_d    = res_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        k_d   = '0;
        res_d = req_i.literal_bits;
        if (accept) begin
          if (req_i.func == FUNC_ATTN) begin
            state_d = ST_ATTN;
          end else if (req_i.apply_update &&
                       (req_i.func == FUNC_TYPE1 || req_i.func == FUNC_TYPE2)) begin
            state_d = ST_FEED;
          end
        end
      end
      ST_ATTN: begin
        if (k_ext >= span_q && k_ext < n_use && !incl_q[s]) begin
          res_d[s] = 1'b0;
        end
        k_d = k_q + lit_idx_t'(1);
        if (k_q == K_LAST) begin
          state_d = ST_ATTN_OUT;
        end
      end
      ST_ATTN_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FEED: begin
        k_d = k_q + lit_idx_t'(1);
        if (k_q == K_LAST) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      count_q     <= CNT_W'(MAX_LITERALS);
      span_q      <= CNT_W'(MAX_LITERALS);
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LITERAL_COUNT:  count_q <= cfg_data_i;
          CFG_ATTENTION_SPAN: span_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      func_q <= req_i.func;
      lits_q <= req_i.literal_bits;
      incl_q <= req_i.included_bits;
      dem_q  <= req_i.demote_bits;
    end else if (state_q == ST_FEED) begin
      dem_q <= dem_q >> 1;
    end
    if (out_load) begin
      out_bits_q <= res_q;
    end
  end

  `ASSERT_PROP(a_attn_done, clk_i, rst_ni, state_q == ST_ATTN && k_q == K_LAST |=> state_q == ST_ATTN_OUT, "attention walk overran")
  `ASSERT_PROP(a_flush_one, clk_i, rst_ni, state_q == ST_FLUSH |=> state_q == ST_IDLE, "flush longer than one cycle")
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, state_q == ST_ATTN_OUT && out_valid_q && !res_o.ready |=> state_q == ST_ATTN_OUT && $stable(out_bits_q), "result overwritten while waiting")

endmodule
